>>> sv/lsc_pkg.sv
// Shared types, widths and register codes for the line segment clipper.
package lsc_pkg;

  // Vertex: 16 signed Q7.8 components, vector v (clip, eye, color, tex) at v*4+k.
  typedef logic signed [15:0] comp_t;
  typedef comp_t [15:0] vtx_t;

  typedef struct packed {
    vtx_t v0;
    vtx_t v1;
    logic ok;
  } seg_t;

  // Plane description: user plane, or frustum axis with the sign of c in w +/- c.
  typedef struct packed {
    logic       user;
    logic [1:0] axis;
    logic       neg;
  } pkind_t;

  localparam int USER_PLANES = 6;
  localparam int FRUSTUM_PLANES = 6;
  localparam int NUM_PLANES = FRUSTUM_PLANES + USER_PLANES;

  localparam int EYE_BASE = 4;
  localparam int W_IDX = 3;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_PLANE_FIRST = 3'd1;
  localparam logic [2:0] REG_PLANE_LAST = 3'd6;

  function automatic pkind_t plane_kind(input int p);
    pkind_t k;
    k.user = (p >= FRUSTUM_PLANES);
    k.neg = p[0];
    unique case (p / 2)
      0: k.axis = 2'd2;
      1: k.axis = 2'd0;
      2: k.axis = 2'd1;
      default: k.axis = 2'd0;
    endcase
    return k;
  endfunction

endpackage

>>> sv/line_segment_clipper_top.sv
// Top level of the line segment clipper: configuration registers and the chain of plane stages.
//
// A request on the in_ channel carries one segment (two vertices, each with clip, eye,
// color and texture vectors in packed Q7.8). The segment passes six frustum planes
// (z, -z, x, -x, y, -y against w) and then the six user planes, each enabled by its
// bit in plane_enable and tested on eye coordinates against its coefficient register.
// Every plane is a 23-stage pipeline: distance terms, distance sum, inside test and
// denominator, multiply, rounding prep, 17 divider stages at one quotient bit each,
// and the vertex update. One segment is accepted every cycle while the receiver keeps out_tready
// high. The out_ request gives visible on tuser and the clipped vertices on tdata, all zero for
// a rejected segment.
// Each stage loads when it is empty or when its successor moves, so a stalled receiver
// only holds the stages that are full; empty stages keep filling and in_tready stays
// high until the whole chain is full. Nothing is dropped or repeated.
// Reset clears every valid bit, plane_enable and the plane coefficients. The user must write
// configuration via cfg_wen/cfg_index/cfg_wdata while no segment is in flight; not enforced.
module line_segment_clipper_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_clip_pos, first_eye_pos, first_color, first_texcoord,
  // second_clip_pos, second_eye_pos, second_color, second_texcoord
  input  logic [511:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_first_clip, out_first_eye, out_first_color, out_first_tex,
  // out_second_clip, out_second_eye, out_second_color, out_second_tex
  output logic [511:0] out_tdata,
  // visible
  output logic         out_tuser
);
  import lsc_pkg::*;

  logic [USER_PLANES-1:0] plane_enable_r;
  logic [63:0] coef_r [USER_PLANES];

  // Registers beyond the list, and enable bits of absent planes, are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_enable_r <= '0;
      for (int i = 0; i < USER_PLANES; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_wen) begin
      if (cfg_index == REG_ENABLE) begin
        plane_enable_r <= cfg_wdata[USER_PLANES-1:0];
      end
      for (int i = 0; i < USER_PLANES; i++) begin
        if (cfg_index == REG_PLANE_FIRST + 3'(i)) begin
          coef_r[i] <= cfg_wdata;
        end
      end
    end
  end

  logic ch_valid [NUM_PLANES+1];
  logic ch_ready [NUM_PLANES+1];
  seg_t ch_seg [NUM_PLANES+1];

  assign ch_valid[0] = in_tvalid;
  assign in_tready = ch_ready[0];
  assign ch_seg[0].v0 = in_tdata[255:0];
  assign ch_seg[0].v1 = in_tdata[511:256];
  assign ch_seg[0].ok = 1'b1;

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    logic en;
    logic [63:0] cf;
    if (p < FRUSTUM_PLANES) begin : g_fr
      assign en = 1'b1;
      assign cf = '0;
    end else begin : g_us
      assign en = plane_enable_r[p-FRUSTUM_PLANES];
      assign cf = coef_r[p-FRUSTUM_PLANES];
    end
    lsc_plane u_plane (
      .clk      (clk),
      .rst_n    (rst_n),
      .kind     (plane_kind(p)),
      .plane_en (en),
      .coef     (cf),
      .in_valid (ch_valid[p]),
      .in_ready (ch_ready[p]),
      .in_seg   (ch_seg[p]),
      .out_valid(ch_valid[p+1]),
      .out_ready(ch_ready[p+1]),
      .out_seg  (ch_seg[p+1])
    );
  end

  assign ch_ready[NUM_PLANES] = out_tready;
  assign out_tvalid = ch_valid[NUM_PLANES];
  assign out_tuser = ch_seg[NUM_PLANES].ok;
  // A rejected segment reports zero vectors.
  assign out_tdata = ch_seg[NUM_PLANES].ok ?
                     {ch_seg[NUM_PLANES].v1, ch_seg[NUM_PLANES].v0} : '0;

endmodule

>>> sv/lsc_plane.sv
// One clipping plane: distance, interpolation by a bit-per-stage divider, vertex replacement.
module lsc_plane (
  input  logic           clk,
  input  logic           rst_n,
  input  lsc_pkg::pkind_t kind,
  input  logic           plane_en,
  input  logic [63:0]    coef,
  input  logic           in_valid,
  output logic           in_ready,
  input  lsc_pkg::seg_t  in_seg,
  output logic           out_valid,
  input  logic           out_ready,
  output lsc_pkg::seg_t  out_seg
);
  import lsc_pkg::*;

  localparam int QW = 17;
  localparam int RW = 55;

  function automatic logic signed [31:0] sx32(input logic signed [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  // Stage 1: distance terms.
  logic s1_v_r;
  seg_t s1_seg_r;
  logic signed [31:0] s1_t_r [2][4];
  logic signed [31:0] t_nxt [2][4];
  // Stage 2: distances.
  logic s2_v_r;
  seg_t s2_seg_r;
  logic signed [34:0] s2_a_r, s2_b_r;
  // Stage 3: inside tests, denominator, component differences.
  logic s3_v_r, s3_act_r, s3_in0_r, s3_dneg_r;
  seg_t s3_seg_r;
  logic signed [34:0] s3_a_r;
  logic [35:0] s3_dabs_r;
  logic signed [16:0] s3_diff_r [16];
  // Stage 4: numerators.
  logic s4_v_r, s4_act_r, s4_in0_r, s4_dneg_r;
  seg_t s4_seg_r;
  logic [35:0] s4_dabs_r;
  logic signed [51:0] s4_num_r [16];
  // Divider stages: index 0 is loaded with the rounded dividend.
  logic dv_v_r [QW+1];
  logic dv_act_r [QW+1];
  logic dv_in0_r [QW+1];
  seg_t dv_seg_r [QW+1];
  logic [36:0] dv_d2_r [QW+1];
  logic [RW-1:0] dv_rem_r [QW+1][16];
  logic [QW-1:0] dv_q_r [QW+1][16];
  logic dv_neg_r [QW+1][16];
  logic dv_en [QW+1];
  // Final stage.
  logic f_v_r;
  seg_t f_seg_r;

  logic en1, en2, en3, en4, en_f;

  assign en_f = !f_v_r || out_ready;
  assign dv_en[QW] = !dv_v_r[QW] || en_f;
  for (genvar j = 0; j < QW; j++) begin : g_en
    assign dv_en[j] = !dv_v_r[j] || dv_en[j+1];
  end
  assign en4 = !s4_v_r || dv_en[0];
  assign en3 = !s3_v_r || en4;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;
  assign in_ready = en1;

  always_comb begin
    vtx_t vx;
    comp_t c;
    for (int vv = 0; vv < 2; vv++) begin
      vx = (vv == 0) ? in_seg.v0 : in_seg.v1;
      c = vx[{2'b00, kind.axis}];
      for (int k = 0; k < 4; k++) begin
        if (kind.user) begin
          t_nxt[vv][k] = $signed(coef[16*k +: 16]) * $signed(vx[EYE_BASE+k]);
        end else if (k == 0) begin
          t_nxt[vv][k] = sx32(vx[W_IDX]);
        end else if (k == 1) begin
          t_nxt[vv][k] = kind.neg ? sx32(c) : -sx32(c);
        end else begin
          t_nxt[vv][k] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= in_valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en4) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [35:0] den;
    logic in0, in1;
    seg_t sg;
    if (en1) begin
      s1_seg_r <= in_seg;
      s1_t_r <= t_nxt;
    end
    if (en2) begin
      s2_seg_r <= s1_seg_r;
      s2_a_r <= 35'(s1_t_r[0][0]) + 35'(s1_t_r[0][1]) + 35'(s1_t_r[0][2]) + 35'(s1_t_r[0][3]);
      s2_b_r <= 35'(s1_t_r[1][0]) + 35'(s1_t_r[1][1]) + 35'(s1_t_r[1][2]) + 35'(s1_t_r[1][3]);
    end
    if (en3) begin
      in0 = !s2_a_r[34];
      in1 = !s2_b_r[34];
      den = {s2_a_r[34], s2_a_r} - {s2_b_r[34], s2_b_r};
      sg = s2_seg_r;
      sg.ok = s2_seg_r.ok && !(plane_en && !in0 && !in1);
      s3_seg_r <= sg;
      s3_act_r <= s2_seg_r.ok && plane_en && (in0 ^ in1);
      s3_in0_r <= in0;
      s3_a_r <= s2_a_r;
      s3_dneg_r <= den[35];
      s3_dabs_r <= den[35] ? 36'(-den) : 36'(den);
      for (int j = 0; j < 16; j++) begin
        s3_diff_r[j] <= 17'(s2_seg_r.v1[j]) - 17'(s2_seg_r.v0[j]);
      end
    end
    if (en4) begin
      s4_seg_r <= s3_seg_r;
      s4_act_r <= s3_act_r;
      s4_in0_r <= s3_in0_r;
      s4_dneg_r <= s3_dneg_r;
      s4_dabs_r <= s3_dabs_r;
      for (int j = 0; j < 16; j++) begin
        s4_num_r[j] <= s3_diff_r[j] * s3_a_r;
      end
    end
  end

  // Rounded quotient: floor((2|num| + d) / 2d), one quotient bit per stage.
  always_ff @(posedge clk) begin
    logic signed [51:0] numf;
    logic [50:0] mag;
    if (dv_en[0]) begin
      dv_seg_r[0] <= s4_seg_r;
      dv_act_r[0] <= s4_act_r;
      dv_in0_r[0] <= s4_in0_r;
      dv_d2_r[0] <= {s4_dabs_r, 1'b0};
      for (int j = 0; j < 16; j++) begin
        numf = s4_dneg_r ? -s4_num_r[j] : s4_num_r[j];
        mag = numf[51] ? 51'(-numf) : 51'(numf);
        dv_neg_r[0][j] <= numf[51];
        dv_rem_r[0][j] <= RW'({mag, 1'b0}) + RW'(s4_dabs_r);
        dv_q_r[0][j] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (dv_en[0]) begin
      dv_v_r[0] <= s4_v_r;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (dv_en[j+1]) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end
    always_ff @(posedge clk) begin
      logic [RW-1:0] sub;
      if (dv_en[j+1]) begin
        dv_seg_r[j+1] <= dv_seg_r[j];
        dv_act_r[j+1] <= dv_act_r[j];
        dv_in0_r[j+1] <= dv_in0_r[j];
        dv_d2_r[j+1] <= dv_d2_r[j];
        sub = RW'(dv_d2_r[j]) << SH;
        for (int c = 0; c < 16; c++) begin
          dv_neg_r[j+1][c] <= dv_neg_r[j][c];
          if (dv_rem_r[j][c] >= sub) begin
            dv_rem_r[j+1][c] <= dv_rem_r[j][c] - sub;
            dv_q_r[j+1][c] <= dv_q_r[j][c] | (QW'(1) << SH);
          end else begin
            dv_rem_r[j+1][c] <= dv_rem_r[j][c];
            dv_q_r[j+1][c] <= dv_q_r[j][c];
          end
        end
      end
    end
  end

  // Final stage: new point = p0 + signed quotient, saturated; replace the outside end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en_f) begin
      f_v_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    vtx_t nv;
    logic signed [18:0] r;
    logic signed [18:0] qs;
    seg_t fs;
    if (en_f) begin
      for (int c = 0; c < 16; c++) begin
        qs = dv_neg_r[QW][c] ? -$signed({2'b00, dv_q_r[QW][c]}) : $signed({2'b00, dv_q_r[QW][c]});
        r = 19'(dv_seg_r[QW].v0[c]) + qs;
        if (r > 19'sd32767) begin
          nv[c] = 16'sh7fff;
        end else if (r < -19'sd32768) begin
          nv[c] = 16'sh8000;
        end else begin
          nv[c] = r[15:0];
        end
      end
      fs = dv_seg_r[QW];
      if (dv_act_r[QW]) begin
        if (dv_in0_r[QW]) begin
          fs.v1 = nv;
        end else begin
          fs.v0 = nv;
        end
      end
      f_seg_r <= fs;
    end
  end

  assign out_valid = f_v_r;
  assign out_seg = f_seg_r;

endmodule

>>> test/line_segment_clipper_top_test.sv
// Testbench for the line segment clipper: random and directed segments checked against a local clipper.
`timescale 1ns / 100ps

module line_segment_clipper_top_test;
  import lsc_pkg::*;

  // Clock and the block's ports. Every input is driven to a known value from time zero.
  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wen = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [511:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [511:0] out_tdata;
  logic         out_tuser;

  // The clipped segment as it should appear on the result channel.
  typedef struct {
    logic         visible;
    logic [511:0] verts;
  } clip_result_t;

  clip_result_t expected_segments[$];

  // Local copy of the configuration registers.
  logic [5:0]  enabled_planes;
  logic [63:0] user_plane[6];

  int  error_count = 0;
  longint cycle_count = 0;
  // Idling of either side can be switched off for a long stretch.
  bit  send_idle_on = 1'b1;
  bit  recv_idle_on = 1'b1;

  localparam int LATENCY = 276;
  localparam longint CYCLE_LIMIT = 2_000_000;

  line_segment_clipper_top DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Interpolation of one component: p0 + round((p1 - p0) * a / den),
  // ties away from zero, saturated to 16 bits.
  function automatic longint lerp_component(longint p0, longint p1, longint a, longint den);
    longint num, mag, q, r;
    num = (p1 - p0) * a;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    r = p0 + ((num < 0) ? -q : q);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // Clips the two vertices (16 components each) against one plane with distances a, b.
  // Returns 0 when both endpoints are outside.
  function automatic bit clip_to_plane(ref longint v0[16], ref longint v1[16],
                                       input longint a, input longint b);
    longint t[16];
    if (a < 0 && b < 0) return 1'b0;
    if (a >= 0 && b >= 0) return 1'b1;
    for (int j = 0; j < 16; j++) t[j] = lerp_component(v0[j], v1[j], a, a - b);
    if (a >= 0) v1 = t;
    else v0 = t;
    return 1'b1;
  endfunction

  function automatic longint eye_distance(logic [63:0] plane, longint v[16]);
    longint s;
    s = 0;
    for (int k = 0; k < 4; k++)
      s += longint'($signed(plane[16*k +: 16])) * v[EYE_BASE + k];
    return s;
  endfunction

  // Predicts the clipped segment for one request.
  function automatic clip_result_t clip_segment(logic [511:0] seg);
    longint v0[16], v1[16];
    int axes[3];
    int c;
    bit ok;
    clip_result_t res;
    axes = '{2, 0, 1};
    for (int j = 0; j < 16; j++) begin
      v0[j] = $signed(seg[16*j +: 16]);
      v1[j] = $signed(seg[256 + 16*j +: 16]);
    end
    ok = 1'b1;
    for (int ax = 0; ax < 3 && ok; ax++) begin
      c = axes[ax];
      ok = clip_to_plane(v0, v1, v0[W_IDX] - v0[c], v1[W_IDX] - v1[c]);
      if (ok) ok = clip_to_plane(v0, v1, v0[W_IDX] + v0[c], v1[W_IDX] + v1[c]);
    end
    for (int p = 0; p < USER_PLANES && ok; p++) begin
      if (enabled_planes[p])
        ok = clip_to_plane(v0, v1, eye_distance(user_plane[p], v0),
                           eye_distance(user_plane[p], v1));
    end
    res.visible = ok;
    res.verts = '0;
    if (ok) begin
      for (int j = 0; j < 16; j++) begin
        res.verts[16*j +: 16] = v0[j][15:0];
        res.verts[256 + 16*j +: 16] = v1[j][15:0];
      end
    end
    return res;
  endfunction

  // Register write, only issued while nothing is in flight.
  task automatic write_register(logic [2:0] index, logic [63:0] value);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    if (index == REG_ENABLE) enabled_planes = value[5:0];
    else if (index >= REG_PLANE_FIRST && index <= REG_PLANE_LAST)
      user_plane[index - REG_PLANE_FIRST] = value;
  endtask

  // Sends one segment request, starting at a falling edge; the expectation is queued
  // at acceptance. The task returns at the next falling edge with tvalid still high so
  // that the next request can follow without a gap; whoever stops sending drops it.
  task automatic send_segment(logic [511:0] seg);
    while (send_idle_on && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= seg;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_segments.push_back(clip_segment(seg));
    @(negedge clk);
  endtask

  // Waits until every result has arrived and the pipeline has emptied.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // A random component, biased toward small values and the extremes.
  function automatic logic [15:0] rand_comp;
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($signed($urandom_range(1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // A random vertex, mostly with w positive and near the frustum so that clipping happens.
  function automatic logic [255:0] rand_vertex(bit well_formed);
    logic [255:0] v;
    logic [15:0] w;
    for (int j = 0; j < 16; j++) v[16*j +: 16] = rand_comp();
    if (well_formed) begin
      w = 16'($urandom_range(1024, 64));
      v[48 +: 16] = w;
      for (int k = 0; k < 3; k++)
        v[16*k +: 16] = 16'($signed($urandom_range(4 * w)) - 2 * $signed({1'b0, w}));
    end
    return v;
  endfunction

  function automatic logic [63:0] rand_plane;
    logic [63:0] p;
    for (int k = 0; k < 4; k++) p[16*k +: 16] = 16'($signed($urandom_range(512)) - 256);
    return p;
  endfunction

  // Directed segments: field extremes, on-plane endpoints, full rejection and
  // a segment crossing every frustum plane.
  task automatic test_directed;
    send_segment('0);
    send_segment('1);
    send_segment({8{64'h8000_8000_8000_8000}});
    send_segment({8{64'h7FFF_7FFF_7FFF_7FFF}});
    send_segment({{4{64'h7FFF_8000_7FFF_8000}}, {4{64'h8000_7FFF_8000_7FFF}}});
    // Both endpoints exactly on x = w: distance zero counts as inside.
    send_segment({192'h0, 64'h0100_0000_0000_0100, 192'h0, 64'h0100_0000_0000_0100});
    // Both endpoints beyond z = w: rejected.
    send_segment({192'h5, 64'h0100_0400_0000_0000, 192'h3, 64'h0100_0300_0000_0000});
    // One endpoint inside, one far outside on every axis.
    send_segment({192'h1234_5678_9ABC_DEF0, 64'h0100_0400_0400_0400,
                  192'hFEDC_BA98_7654_3210, 64'h0100_0000_0000_0000});
    send_segment({192'h0, 64'h0100_FC00_FC00_FC00, 192'h0, 64'h0100_0400_0400_0400});
    drain();
  endtask

  // User planes: each plane alone, odd ones with extreme coefficients, then all at once.
  task automatic test_user_planes;
    logic [511:0] seg;
    for (int p = 0; p < USER_PLANES; p++) begin
      write_register(REG_PLANE_FIRST + 3'(p), (p % 2) ? 64'h8000_7FFF_8000_7FFF : rand_plane());
      write_register(REG_ENABLE, 64'(1) << p);
      seg = {rand_vertex(1), rand_vertex(1)};
      send_segment(seg);
      send_segment({rand_vertex(1), rand_vertex(1)});
      drain();
    end
    // Index beyond the list is ignored; enable bits above the planes are ignored.
    write_register(3'd7, '1);
    write_register(REG_ENABLE, '1);
    send_segment({rand_vertex(1), rand_vertex(1)});
    send_segment({rand_vertex(0), rand_vertex(0)});
    drain();
  endtask

  // Random phases under changing configurations, with one phase without any idling.
  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      for (int p = 0; p < USER_PLANES; p++)
        write_register(REG_PLANE_FIRST + 3'(p), ($urandom_range(3) == 0)
                       ? {$urandom, $urandom} : rand_plane());
      write_register(REG_ENABLE, (ph == 0) ? 64'h0 : (ph == 1) ? 64'h3F : 64'($urandom));
      send_idle_on = (ph != 2);
      recv_idle_on = (ph != 2);
      for (int n = 0; n < per_phase; n++) begin
        send_segment({rand_vertex($urandom_range(9) < 8), rand_vertex($urandom_range(9) < 8)});
        // Once per phase, hold off until every result is back.
        if (n == per_phase / 2) begin
          in_tvalid <= 1'b0;
          while (expected_segments.size() != 0) @(posedge clk);
          @(negedge clk);
        end
      end
      drain();
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // Receiver: stalls at random and checks each accepted result in order.
  always @(negedge clk) begin
    if (rst_n) out_tready <= !(recv_idle_on && $urandom_range(99) < 19);
  end

  always @(posedge clk) begin
    clip_result_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_segments.size() == 0) begin
        $error("unexpected result: visible %0b", out_tuser);
        error_count++;
      end else begin
        want = expected_segments.pop_front();
        if (out_tuser !== want.visible) begin
          $error("visible: expected %0b, got %0b", want.visible, out_tuser);
          error_count++;
        end
        for (int f = 0; f < 8; f++) begin
          if (out_tdata[64*f +: 64] !== want.verts[64*f +: 64]) begin
            $error("vector field %0d: expected %h, got %h", f,
                   want.verts[64*f +: 64], out_tdata[64*f +: 64]);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL line_segment_clipper_top");
      $finish;
    end
  end

  initial begin
    enabled_planes = '0;
    for (int p = 0; p < 6; p++) user_plane[p] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_user_planes();
    test_random(6, 220);
    if (expected_segments.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("PASS line_segment_clipper_top");
    end else begin
      $display("FAIL line_segment_clipper_top");
    end
    $finish;
  end

endmodule
